/* hw/rtl/assert_macros.svh */
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/buddy_pkg.sv */
`timescale 1ns / 1ps
package buddy_pkg;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_BIG  = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd2;

   localparam logic [31:0] REGION_BASE_RESET = 32'h0100_0000;

   typedef struct packed {
      logic        func;
      logic [15:0] request_size;
      logic [31:0] block_address;
   } req_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [1:0]  status;
   } rsp_type;

endpackage

/* hw/rtl/buddy_allocator.sv */
`timescale 1ns / 1ps
// Buddy allocator: one request in flight, one response per request.
// Allocate: scan lists upward from the requested order, pop a head or the whole region, split down.
// Free: search each order's list for the buddy, unlink it and merge up, else push the block.
// Size too large: straight to the response. A stalled response holds the engine in its last state.
// The next request is taken in the idle state entered after the response is loaded.
// Synchronous reset empties all lists, sets the region free, loads region_base; links keep data.
`include "assert_macros.svh"
module buddy_allocator #(
   parameter int ORDERS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  buddy_pkg::req_type    req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output buddy_pkg::rsp_type    rsp_data,
   input  logic                  csr_write,
   input  logic [31:0]           csr_data
);

   localparam int OW = ORDERS;                    // offset width
   localparam int KW = $clog2(ORDERS + 2);        // order width
   localparam int SW = ORDERS + 1;                // walk step counter

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DEC   = 4'd1;
   localparam logic [3:0] ST_ASCAN = 4'd2;
   localparam logic [3:0] ST_ARD   = 4'd3;
   localparam logic [3:0] ST_AHEAD = 4'd4;
   localparam logic [3:0] ST_SPLIT = 4'd5;
   localparam logic [3:0] ST_FSTART= 4'd6;
   localparam logic [3:0] ST_FRD   = 4'd7;
   localparam logic [3:0] ST_FCHK  = 4'd8;
   localparam logic [3:0] ST_FUNL  = 4'd9;
   localparam logic [3:0] ST_PUSH  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [31:0]   base_ff;
   logic          top_free_ff, top_free_in;
   logic [ORDERS-1:0] head_v_ff, head_v_in;
   logic [OW-1:0] head_ff [ORDERS];
   logic [OW-1:0] head_in [ORDERS];
   logic [OW:0]   links [2**ORDERS];
   logic [OW:0]   rd_data_ff;

   logic          func_ff, func_in;
   logic [4:0]    n_ff, n_in;          // requested order, up to 16
   logic [31:0]   addr_ff, addr_in;
   logic [15:0]   size_ff, size_in;
   logic [KW-1:0] k_ff, k_in;
   logic [OW-1:0] off_ff, off_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [OW-1:0] prev_ff, prev_in;
   logic          have_prev_ff, have_prev_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic          rsp_valid_ff, rsp_valid_in;
   buddy_pkg::rsp_type rsp_ff, rsp_in;
   buddy_pkg::rsp_type res_ff, res_in;

   logic          mem_we;
   logic [OW-1:0] mem_waddr, mem_raddr;
   logic [OW:0]   mem_wdata;

   logic [OW-1:0] buddy;
   logic [4:0]    order_calc;
   logic [16:0]   size_m1;

   // order = bit length of (size-1), size 0 counts as 1
   always_comb begin
      size_m1 = (size_ff == 16'd0) ? 17'd0 : {1'b0, size_ff} - 17'd1;
      order_calc = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (size_m1[i]) order_calc = 5'(i + 1);
      end
   end

   assign buddy = off_ff ^ (OW'(1) << k_ff);

   always_ff @(posedge clock) begin
      if (mem_we) links[mem_waddr] <= mem_wdata;
      rd_data_ff <= links[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      top_free_in  = top_free_ff;
      head_v_in    = head_v_ff;
      head_in      = head_ff;
      func_in      = func_ff;
      n_in         = n_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      off_in       = off_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = off_ff;
      mem_wdata    = '0;
      mem_raddr    = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_data.func;
               size_in  = req_data.request_size;
               addr_in  = req_data.block_address;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            n_in = order_calc;
            res_in.granted_address = '0;
            res_in.status = buddy_pkg::STATUS_OK;
            if ({27'd0, order_calc} > ORDERS) begin
               res_in.status = buddy_pkg::STATUS_TOO_BIG;
               state_in = ST_DONE;
            end else if (func_ff == buddy_pkg::FUNC_ALLOC) begin
               k_in = KW'(order_calc);
               state_in = ST_ASCAN;
            end else begin
               k_in = KW'(order_calc);
               off_in = OW'(addr_ff - base_ff) &
                        ~((OW'(1) << order_calc) - OW'(1));
               state_in = ST_FSTART;
            end
         end
         ST_ASCAN: begin
            if (32'(k_ff) < ORDERS) begin
               if (head_v_ff[k_ff]) begin
                  off_in = head_ff[k_ff];
                  cur_in = head_ff[k_ff];
                  state_in = ST_ARD;
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end else if (top_free_ff) begin
               top_free_in = 1'b0;
               off_in = '0;
               state_in = ST_SPLIT;
            end else begin
               res_in.status = buddy_pkg::STATUS_NO_SPACE;
               state_in = ST_DONE;
            end
         end
         ST_ARD: begin
            mem_raddr = cur_ff;
            state_in = ST_AHEAD;
         end
         ST_AHEAD: begin
            head_v_in[k_ff] = rd_data_ff[OW];
            head_in[k_ff]   = rd_data_ff[OW-1:0];
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if ({27'd0, n_ff} < 32'(k_ff)) begin
               mem_we    = 1'b1;
               mem_waddr = off_ff ^ (OW'(1) << (k_ff - KW'(1)));
               mem_wdata = {head_v_ff[k_ff-KW'(1)], head_ff[k_ff-KW'(1)]};
               head_v_in[k_ff-KW'(1)] = 1'b1;
               head_in[k_ff-KW'(1)]   = mem_waddr;
               k_in = k_ff - KW'(1);
            end else begin
               res_in.granted_address = base_ff + 32'(off_ff);
               state_in = ST_DONE;
            end
         end
         ST_FSTART: begin
            if (32'(k_ff) >= ORDERS) begin
               top_free_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               cur_in = head_ff[k_ff];
               have_prev_in = 1'b0;
               steps_in = '0;
               if (head_v_ff[k_ff]) state_in = ST_FRD;
               else state_in = ST_PUSH;
            end
         end
         ST_FRD: begin
            mem_raddr = cur_ff;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            if (cur_ff == buddy) begin
               state_in = ST_FUNL;
            end else if (rd_data_ff[OW] && (32'(steps_ff) + 1 < (2**ORDERS))) begin
               prev_in = cur_ff;
               have_prev_in = 1'b1;
               cur_in = rd_data_ff[OW-1:0];
               steps_in = steps_ff + SW'(1);
               state_in = ST_FRD;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_FUNL: begin
            // rd_data_ff still holds next link of the buddy
            if (have_prev_ff) begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff;
               mem_wdata = rd_data_ff;
            end else begin
               head_v_in[k_ff] = rd_data_ff[OW];
               head_in[k_ff]   = rd_data_ff[OW-1:0];
            end
            if (buddy < off_ff) off_in = buddy;
            k_in = k_ff + KW'(1);
            state_in = ST_FSTART;
         end
         ST_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = off_ff;
            mem_wdata = {head_v_ff[k_ff], head_ff[k_ff]};
            head_v_in[k_ff] = 1'b1;
            head_in[k_ff]   = off_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // load the output register only once the previous response has left
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_free_ff  <= 1'b1;
         head_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= buddy_pkg::REGION_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         top_free_ff  <= top_free_in;
         head_v_ff    <= head_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) base_ff <= csr_data;
      end
      head_ff      <= head_in;
      func_ff      <= func_in;
      n_ff         <= n_in;
      addr_ff      <= addr_in;
      size_ff      <= size_in;
      k_ff         <= k_in;
      off_ff       <= off_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      steps_ff     <= steps_in;
      rsp_ff       <= rsp_in;
      res_ff       <= res_in;
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "accept did not start work")
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && rsp_data.status != buddy_pkg::STATUS_OK, rsp_data.granted_address == 32'd0, "failed request granted an address")
   `ASSERT_IMPLY(a_status_range, clock, reset, rsp_valid, rsp_data.status != 2'd3, "bad status code")

endmodule

/* dv/buddy_checker.sv */
`timescale 1ns / 1ps
module buddy_checker #(
   parameter int ORDERS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  buddy_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  buddy_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic [31:0]         csr_data,
   output int                  fail_count,
   output int                  pending_count
);

   localparam int unsigned SPAN = 1 << ORDERS;
   localparam logic [ORDERS:0] LINK_VALID = {1'b1, {ORDERS{1'b0}}};

   logic [31:0]        base_addr;
   logic [ORDERS:0]    free_heads [ORDERS];
   logic [ORDERS:0]    free_links [SPAN];
   logic               whole_free;
   buddy_pkg::rsp_type expected_q [$];

   function automatic int unsigned size_order(logic [15:0] size);
      int unsigned n;
      n = 0;
      while ((32'd1 << n) < size) n++;
      return n;
   endfunction

   function automatic void push_free(int unsigned k, logic [ORDERS-1:0] off);
      free_links[off] = free_heads[k];
      free_heads[k] = LINK_VALID | {1'b0, off};
   endfunction

   // Unlink target from list k; the walk is bounded so a corrupted list still ends.
   function automatic bit unlink_free(int unsigned k, logic [ORDERS-1:0] target);
      logic [ORDERS:0]   cur;
      logic [ORDERS-1:0] prev, o;
      bit                have_prev;
      int unsigned       steps;
      cur = free_heads[k];
      prev = '0;
      have_prev = 0;
      steps = 0;
      while (cur[ORDERS] && steps < SPAN) begin
         o = cur[ORDERS-1:0];
         if (o == target) begin
            if (have_prev) free_links[prev] = free_links[o];
            else free_heads[k] = free_links[o];
            return 1;
         end
         prev = o;
         have_prev = 1;
         cur = free_links[o];
         steps++;
      end
      return 0;
   endfunction

   function automatic buddy_pkg::rsp_type allocate_or_free(buddy_pkg::req_type req);
      buddy_pkg::rsp_type r;
      int unsigned        n, j, k;
      logic [ORDERS-1:0]  off, buddy;
      bit                 found;
      n = size_order(req.request_size);
      r.granted_address = '0;
      r.status = buddy_pkg::STATUS_OK;
      off = '0;
      found = 0;
      if (n > ORDERS) begin
         r.status = buddy_pkg::STATUS_TOO_BIG;
      end else if (req.func == buddy_pkg::FUNC_ALLOC) begin
         j = n;
         while (j < ORDERS && !found) begin
            if (free_heads[j][ORDERS]) begin
               off = free_heads[j][ORDERS-1:0];
               free_heads[j] = free_links[off];
               found = 1;
            end else begin
               j++;
            end
         end
         if (!found && whole_free) begin
            whole_free = 0;
            off = '0;
            j = ORDERS;
            found = 1;
         end
         if (!found) begin
            r.status = buddy_pkg::STATUS_NO_SPACE;
         end else begin
            while (j > n) begin
               j--;
               push_free(j, off ^ (ORDERS'(1) << j));
            end
            r.granted_address = base_addr + 32'(off);
         end
      end else begin
         off = ORDERS'(req.block_address - base_addr);
         k = n;
         off = off & ~((ORDERS'(1) << k) - ORDERS'(1));
         if (k >= ORDERS) off = '0;
         while (k < ORDERS) begin
            buddy = off ^ (ORDERS'(1) << k);
            if (!unlink_free(k, buddy)) begin
               push_free(k, off);
               break;
            end
            if (buddy < off) off = buddy;
            k++;
         end
         if (k >= ORDERS) whole_free = 1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      buddy_pkg::rsp_type want;
      if (reset) begin
         base_addr = buddy_pkg::REGION_BASE_RESET;
         for (int i = 0; i < ORDERS; i++) free_heads[i] = '0;
         whole_free = 1;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write) base_addr = csr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with none expected: addr %h status %0d", $time,
                        rsp_data.granted_address, rsp_data.status);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (want.granted_address !== rsp_data.granted_address) begin
                  $display("%0t: granted_address expected %h actual %h", $time,
                           want.granted_address, rsp_data.granted_address);
                  fail_count++;
               end
               if (want.status !== rsp_data.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(allocate_or_free(req_data));
      end
      pending_count = expected_q.size();
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

   localparam int ORDERS = 12;
   localparam int CYCLE_LIMIT = 5_000_000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   buddy_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   buddy_pkg::rsp_type rsp_data;
   logic               csr_write = 0;
   logic [31:0]        csr_data = '0;

   int fail_count, pending_count;
   int cycles = 0;
   bit quiet = 0;
   bit long_hold = 0;
   logic [31:0] cur_base = buddy_pkg::REGION_BASE_RESET;

   // blocks granted and not yet freed, as offsets into the region
   int live_off [$];
   int live_ord [$];
   int sent_ord [$];   // order of each accepted allocate up to ORDERS, -1 for other requests

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   buddy_allocator #(.ORDERS(ORDERS)) u_top (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_data
   );

   buddy_checker #(.ORDERS(ORDERS)) u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_data,
      .fail_count, .pending_count
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[buddy_allocator] ERROR");
         $finish;
      end
   end

   // record grants so later frees hit live blocks
   always @(posedge clock) begin
      int o;
      if (!reset && rsp_valid && !rsp_stall && sent_ord.size() > 0) begin
         o = sent_ord.pop_front();
         if (o >= 0 && rsp_data.status == buddy_pkg::STATUS_OK) begin
            live_off.push_back(int'((rsp_data.granted_address - cur_base) & 32'hFFF));
            live_ord.push_back(o);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic int order_of(int size);
      int n;
      n = 0;
      while ((1 << n) < size) n++;
      return n;
   endfunction

   task automatic send(logic func, logic [15:0] size, logic [31:0] addr);
      bit taken;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{func: func, request_size: size, block_address: addr};
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sent_ord.push_back((func == buddy_pkg::FUNC_ALLOC && order_of(size) <= ORDERS) ?
                         order_of(size) : -1);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0 || sent_ord.size() != 0) @(posedge clock);
   endtask

   task automatic write_base(logic [31:0] value);
      drain();
      repeat (60) @(posedge clock);
      csr_write <= 1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      cur_base = value;
   endtask

   function automatic logic [15:0] size_for(int o);
      if (o == 0) return 16'($urandom_range(0, 1));
      return 16'($urandom_range((1 << (o - 1)) + 1, 1 << o));
   endfunction

   task automatic alloc_order(int o);
      send(buddy_pkg::FUNC_ALLOC, size_for(o), $urandom());
   endtask

   // free a random live block, with junk in the bits below its alignment
   task automatic free_live();
      int i, o, off;
      i = $urandom_range(0, live_off.size() - 1);
      o = live_ord[i];
      off = live_off[i];
      live_off.delete(i);
      live_ord.delete(i);
      send(buddy_pkg::FUNC_FREE, size_for(o),
           cur_base + 32'(off) + ((o >= ORDERS) ? 32'($urandom_range(0, 4095))
                                                 : 32'($urandom_range(0, (1 << o) - 1))));
   endtask

   task automatic random_items(int count);
      int o;
      for (int t = 0; t < count; t++) begin
         if ($urandom_range(0, 99) < 3) begin
            send(1'($urandom_range(0, 1)), 16'($urandom_range(4097, 65535)), $urandom());
         end else if (live_off.size() > 0 && ($urandom_range(0, 99) < 45 || live_off.size() > 40)) begin
            free_live();
         end else begin
            o = ($urandom_range(0, 19) == 0) ? $urandom_range(7, ORDERS) : $urandom_range(0, 6);
            alloc_order(o);
         end
         // grants must be seen before they can be freed
         if (live_off.size() == 0 && sent_ord.size() > 0) drain();
      end
   endtask

   task automatic free_all();
      drain();
      while (live_off.size() > 0) free_live();
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: extremes, every operation, every special case
      send(buddy_pkg::FUNC_ALLOC, 16'd0, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd1, 32'hFFFF_FFFF);
      send(buddy_pkg::FUNC_ALLOC, 16'hFFFF, 32'h0);
      send(buddy_pkg::FUNC_FREE, 16'hFFFF, 32'hFFFF_FFFF);
      send(buddy_pkg::FUNC_ALLOC, 16'd4097, 32'h0);
      free_all();
      send(buddy_pkg::FUNC_ALLOC, 16'd4096, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd1, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd4096, 32'h0);
      free_all();
      send(buddy_pkg::FUNC_ALLOC, 16'd2048, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd2047, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd2, 32'h0);
      free_all();
      send(buddy_pkg::FUNC_ALLOC, 16'd3, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd100, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd1000, 32'h0);
      send(buddy_pkg::FUNC_ALLOC, 16'd1, 32'h0);
      free_all();

      random_items(200);
      drain();   // sender waits for every response
      random_items(50);
      free_all();

      write_base(32'h0000_0000);
      random_items(150);
      long_hold = 1;
      random_items(100);
      free_all();

      write_base(32'hFFFF_F000);
      random_items(200);
      free_all();

      write_base($urandom());
      random_items(200);
      free_all();

      write_base(32'hFFFF_FFFF);
      quiet = 1;
      random_items(150);
      free_all();

      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("[buddy_allocator] OK");
      else $display("[buddy_allocator] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/buddy_pkg.sv
hw/rtl/buddy_allocator.sv
dv/buddy_checker.sv
dv/tb_top.sv
